[design/fde_pkg.sv]
`default_nettype none

package fde_pkg;

    // How far an item's result is settled when it leaves the front end.
    localparam logic [1:0] KIND_ARITH   = 2'd0;  // d still has to be computed
    localparam logic [1:0] KIND_SPECIAL = 2'd1;  // d is known (NaN or infinity)
    localparam logic [1:0] KIND_FINAL   = 2'd2;  // delta word is known already

    localparam logic REG_FILTER_ENABLE = 1'b0;
    localparam logic REG_THRESHOLD     = 1'b1;

    localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
    localparam logic [10:0] MAX_GAP      = 11'd50;
    localparam logic [63:0] MINUS_ZERO   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN  = 64'hfff8_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] word;
        logic [10:0] em;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic        sign;
        logic        sub;
        logic [10:0] e_large;
        logic [55:0] m_large;
        logic [55:0] m_small;
    } st1_t;

    typedef struct packed {
        side_t       side;
        logic        sign;
        logic [10:0] e_large;
        logic [56:0] sum;
        logic [5:0]  lz;
    } st2_t;

endpackage

`default_nettype wire

[design/float_delta_encoder_core.sv]
// Channel   Direction  Width  Contents
// s_axis    in         128    tdata: minuend [63:0], subtrahend [127:64]
// m_axis    out        64+1   tdata: delta_word [63:0]; tuser: out_of_range
// cfg       in         1+64   register index, write data; written when cfg_we is high
//
// One beat enters per cycle while the output is not stalled. Its result passes
// through the front end (classify, swap, align), the mantissa adder with
// leading-zero count, normalize and round, and the filter and re-encode
// stage, each closed by a register, and is then offered on m_axis. All stages
// move together; while the output beat is not taken the whole pipe holds and
// s_axis_tready is low. Reset clears the valid bits and both configuration
// registers; no clearing pass is needed.
`default_nettype none

module float_delta_encoder_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // minuend, subtrahend
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata,   // delta_word
    output logic              m_axis_tuser,   // out_of_range
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [63:0]  cfg_data
);
    import fde_pkg::*;

    logic        filter_enable_reg;
    logic [63:0] threshold_reg;
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    st1_t        st1_next, st1_reg;
    st2_t        st2_next, st2_reg;
    side_t       st3_next, st3_reg;
    logic [63:0] word_next, word_reg;
    logic        oor_next, oor_reg;
    logic        advance;

    // The pipe moves whenever the output register is empty or being drained.
    assign advance       = !v4_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = word_reg;
    assign m_axis_tuser  = oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= 1'b0;
            threshold_reg     <= 64'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILTER_ENABLE: filter_enable_reg <= cfg_data[0];
                REG_THRESHOLD:     threshold_reg     <= cfg_data;
                default:           threshold_reg     <= threshold_reg;
            endcase
        end
    end

    fde_align u_align (
        .minuend    (s_axis_tdata[63:0]),
        .subtrahend (s_axis_tdata[127:64]),
        .st1        (st1_next)
    );

    fde_addsub u_addsub (
        .st1 (st1_reg),
        .st2 (st2_next)
    );

    fde_round u_round (
        .st2 (st2_reg),
        .st3 (st3_next)
    );

    fde_encode u_encode (
        .st3             (st3_reg),
        .filter_enable   (filter_enable_reg),
        .threshold_value (threshold_reg),
        .delta_word      (word_next),
        .out_of_range    (oor_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st1_reg  <= st1_next;
            st2_reg  <= st2_next;
            st3_reg  <= st3_next;
            word_reg <= word_next;
            oor_reg  <= oor_next;
        end
    end

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v1_reg)
        else $error("accepted beat did not enter the first stage");

    a_hold_output: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

`default_nettype wire

[design/fde_align.sv]
`default_nettype none

module fde_align (
    input  wire logic [63:0] minuend,
    input  wire logic [63:0] subtrahend,
    output fde_pkg::st1_t    st1
);
    import fde_pkg::*;

    logic [63:0]  b;
    logic [10:0]  ea, eb, el, es, el_eff, es_eff, dexp;
    logic [51:0]  fa, fb;
    logic         a_nan, s_nan, a_inf, b_inf, equal, a_big;
    logic [55:0]  ml, ms;
    logic [5:0]   sh;
    logic [111:0] wide;

    always_comb
    begin
        b     = {~subtrahend[63], subtrahend[62:0]};
        ea    = minuend[62:52];
        eb    = b[62:52];
        fa    = minuend[51:0];
        fb    = b[51:0];
        a_nan = (ea == EXP_ALL_ONES) && (fa != 52'd0);
        s_nan = (eb == EXP_ALL_ONES) && (fb != 52'd0);
        a_inf = (ea == EXP_ALL_ONES) && (fa == 52'd0);
        b_inf = (eb == EXP_ALL_ONES) && (fb == 52'd0);
        equal = !a_nan && !s_nan && ((minuend == subtrahend) ||
                ((minuend[62:0] == 63'd0) && (subtrahend[62:0] == 63'd0)));

        a_big = minuend[62:0] >= b[62:0];
        el    = a_big ? ea : eb;
        es    = a_big ? eb : ea;
        el_eff = (el == 11'd0) ? 11'd1 : el;
        es_eff = (es == 11'd0) ? 11'd1 : es;
        ml    = {el != 11'd0, a_big ? fa : fb, 3'b000};
        ms    = {es != 11'd0, a_big ? fb : fa, 3'b000};
        dexp  = el_eff - es_eff;
        sh    = (dexp > 11'd56) ? 6'd56 : dexp[5:0];
        wide  = {ms, 56'd0} >> sh;

        st1.side.em   = minuend[62:52];
        st1.side.kind = KIND_ARITH;
        st1.side.word = 64'd0;
        if (equal)
        begin
            st1.side.kind = KIND_FINAL;
        end
        else if (minuend[62:0] == 63'd0)
        begin
            st1.side.kind = KIND_FINAL;
            st1.side.word = MINUS_ZERO;
        end
        else if (a_nan)
        begin
            st1.side.kind = KIND_SPECIAL;
            st1.side.word = minuend | QUIET_BIT;
        end
        else if (s_nan)
        begin
            st1.side.kind = KIND_SPECIAL;
            st1.side.word = subtrahend | QUIET_BIT;
        end
        else if (a_inf && b_inf)
        begin
            st1.side.kind = KIND_SPECIAL;
            st1.side.word = (minuend[63] != b[63]) ? DEFAULT_NAN : minuend;
        end
        else if (a_inf)
        begin
            st1.side.kind = KIND_SPECIAL;
            st1.side.word = minuend;
        end
        else if (b_inf)
        begin
            st1.side.kind = KIND_SPECIAL;
            st1.side.word = b;
        end

        st1.sign    = a_big ? minuend[63] : b[63];
        st1.sub     = minuend[63] ^ b[63];
        st1.e_large = el_eff;
        st1.m_large = ml;
        st1.m_small = wide[111:56] | {55'd0, |wide[55:0]};
    end

endmodule

`default_nettype wire

[design/fde_addsub.sv]
`default_nettype none

module fde_addsub (
    input  wire fde_pkg::st1_t st1,
    output fde_pkg::st2_t      st2
);
    import fde_pkg::*;

    logic [56:0] sum;
    logic [5:0]  lz;

    always_comb
    begin
        sum = st1.sub ? ({1'b0, st1.m_large} - {1'b0, st1.m_small})
                      : ({1'b0, st1.m_large} + {1'b0, st1.m_small});
        lz = 6'd56;
        for (int i = 0; i < 56; i++)
        begin
            if (sum[i])
            begin
                lz = 6'(55 - i);
            end
        end
        st2.side    = st1.side;
        st2.sign    = st1.sign;
        st2.e_large = st1.e_large;
        st2.sum     = sum;
        st2.lz      = lz;
    end

endmodule

`default_nettype wire

[design/fde_round.sv]
`default_nettype none

module fde_round (
    input  wire fde_pkg::st2_t st2,
    output fde_pkg::side_t     st3
);
    import fde_pkg::*;

    logic [55:0] n;
    logic [11:0] e_norm;
    logic [10:0] lim, e_field;
    logic [5:0]  sh;
    logic        inc, ovf;
    logic [62:0] v;

    always_comb
    begin
        lim = st2.e_large - 11'd1;
        sh  = ({5'd0, st2.lz} > lim) ? lim[5:0] : st2.lz;
        ovf = 1'b0;
        if (st2.sum[56])
        begin
            n      = st2.sum[56:1] | {55'd0, st2.sum[0]};
            e_norm = {1'b0, st2.e_large} + 12'd1;
            ovf    = e_norm[10:0] == EXP_ALL_ONES;
        end
        else
        begin
            n      = st2.sum[55:0] << sh;
            e_norm = {1'b0, st2.e_large} - {6'd0, sh};
        end
        e_field = n[55] ? e_norm[10:0] : 11'd0;
        inc = n[2] & (n[1] | n[0] | n[3]);
        v = {e_field, n[54:3]} + {62'd0, inc};
        if (ovf)
        begin
            v = {EXP_ALL_ONES, 52'd0};
        end

        st3 = st2.side;
        if (st2.side.kind == KIND_ARITH)
        begin
            st3.word = {(st2.sum != 57'd0) & st2.sign, v};
        end
    end

endmodule

`default_nettype wire

[design/fde_encode.sv]
`default_nettype none

module fde_encode (
    input  wire fde_pkg::side_t st3,
    input  wire logic           filter_enable,
    input  wire logic [63:0]    threshold_value,
    output logic [63:0]         delta_word,
    output logic                out_of_range
);
    import fde_pkg::*;

    logic [63:0] d;
    logic [10:0] ed, k;
    logic [5:0]  k6;
    logic        greater, nan_d, nan_t, filt;
    logic [51:0] frac;

    always_comb
    begin
        d       = st3.word;
        ed      = d[62:52];
        greater = ed > st3.em;
        k       = greater ? (ed - st3.em) : (st3.em - ed);
        k6      = k[5:0];
        nan_d   = (ed == EXP_ALL_ONES) && (d[51:0] != 52'd0);
        nan_t   = (threshold_value[62:52] == EXP_ALL_ONES)
                  && (threshold_value[51:0] != 52'd0);
        filt    = filter_enable && !nan_d && !nan_t && !threshold_value[63]
                  && (d[62:0] < threshold_value[62:0]);
        frac    = (d[51:0] >> (k6 + 6'd2))
                  | (52'd1 << (6'd51 - k6))
                  | (52'(greater) << (6'd50 - k6));

        out_of_range = 1'b0;
        if (st3.kind == KIND_FINAL)
        begin
            delta_word = st3.word;
        end
        else if (filt)
        begin
            delta_word = 64'd0;
        end
        else if (k > MAX_GAP)
        begin
            delta_word   = d;
            out_of_range = 1'b1;
        end
        else
        begin
            delta_word = {d[63], st3.em, frac};
        end
    end

endmodule

`default_nettype wire

[tb/float_delta_encoder_core_tb.sv]
`default_nettype none

module float_delta_encoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fde_pkg::*;

    // Keeps the predicted delta words in arrival order and matches each output
    // beat against the oldest one.
    class delta_scoreboard;
        logic [63:0] exp_word_q[$];
        logic        exp_oor_q[$];
        int          errors;
        logic        filt_en;
        logic [63:0] thresh;

        function new();
            errors  = 0;
            filt_en = 1'b0;
            thresh  = 64'd0;
        endfunction

        // Works out the delta word for one pair of doubles.
        function void note_pair(logic [63:0] m_bits, logic [63:0] s_bits);
            real         m_val;
            real         s_val;
            real         d_val;
            real         t_val;
            logic [63:0] d_bits;
            logic [10:0] em;
            logic [10:0] ed;
            int          gap;
            logic [63:0] frac;
            logic        greater;
            m_val = $bitstoreal(m_bits);
            s_val = $bitstoreal(s_bits);
            if (m_val == s_val)
            begin
                exp_word_q.push_back(64'd0);
                exp_oor_q.push_back(1'b0);
                return;
            end
            if (m_val == 0.0)
            begin
                exp_word_q.push_back(MINUS_ZERO);
                exp_oor_q.push_back(1'b0);
                return;
            end
            d_val = m_val - s_val;
            if (filt_en)
            begin
                t_val = $bitstoreal(thresh);
                if ((d_val >= 0.0 && d_val < t_val) || (d_val < 0.0 && d_val > -t_val))
                begin
                    exp_word_q.push_back(64'd0);
                    exp_oor_q.push_back(1'b0);
                    return;
                end
            end
            d_bits  = $realtobits(d_val);
            em      = m_bits[62:52];
            ed      = d_bits[62:52];
            greater = ed > em;
            gap     = greater ? int'(ed) - int'(em) : int'(em) - int'(ed);
            if (gap > 50)
            begin
                exp_word_q.push_back(d_bits);
                exp_oor_q.push_back(1'b1);
                return;
            end
            frac = {12'd0, d_bits[51:0]} >> (gap + 2);
            frac[51 - gap] = 1'b1;
            frac[50 - gap] = greater;
            exp_word_q.push_back({d_bits[63], em, frac[51:0]});
            exp_oor_q.push_back(1'b0);
        endfunction

        function void check_beat(logic [63:0] word, logic oor);
            logic [63:0] ew;
            logic        eo;
            if (exp_word_q.size() == 0)
            begin
                $error("unexpected beat: delta_word %h", word);
                errors++;
                return;
            end
            ew = exp_word_q.pop_front();
            eo = exp_oor_q.pop_front();
            if (word !== ew)
            begin
                $error("delta_word: expected %h, actual %h", ew, word);
                errors++;
            end
            if (oor !== eo)
            begin
                $error("out_of_range: expected %b, actual %b", eo, oor);
                errors++;
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;    // minuend [63:0], subtrahend [127:64]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;         // delta_word
    logic         m_axis_tuser;         // out_of_range
    logic         cfg_we = 1'b0;
    logic         cfg_index = REG_FILTER_ENABLE;
    logic [63:0]  cfg_data = '0;

    delta_scoreboard sb = new();

    // Idle rates in percent; the receiver may also be parked by the hold-off.
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 1'b0;

    always #4 clk = ~clk;

    float_delta_encoder_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // The receiver decides tready per cycle and checks every beat taken at the
    // edge; the sampled values are those from before the edge's updates.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Drives one pair; the prediction is made at the edge that accepts it.
    task automatic send_pair(logic [63:0] m_bits, logic [63:0] s_bits);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {s_bits, m_bits};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_pair(m_bits, s_bits);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.exp_word_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_FILTER_ENABLE)
            sb.filt_en = value[0];
        else
            sb.thresh = value;
    endtask

    // Random double: mostly nearby magnitudes so the encoding path is busy,
    // with a share of raw patterns and special values.
    function automatic logic [63:0] rand_double(logic [63:0] near);
        logic [63:0] w;
        int          sel;
        w   = {$urandom, $urandom};
        sel = $urandom_range(99);
        if (sel < 55)
            w[62:52] = near[62:52] + 11'($urandom_range(8)) - 11'd4;
        else if (sel < 70)
            w[62:52] = near[62:52] + 11'($urandom_range(120)) - 11'd60;
        else if (sel < 75)
            w[62:52] = EXP_ALL_ONES;
        else if (sel < 80)
            w[62:52] = 11'd0;
        else if (sel < 84)
            w = near;
        else if (sel < 87)
            w = {near[63] ^ 1'b1, near[62:0]};
        else if (sel < 90)
            w = {w[63], 63'd0};
        return w;
    endfunction

    task automatic random_phase(int count);
        logic [63:0] m_bits;
        logic [63:0] s_bits;
        for (int i = 0; i < count; i++)
        begin
            s_bits = {$urandom, $urandom};
            if ($urandom_range(9) < 8)
                s_bits[62:52] = 11'($urandom_range(1100, 950));
            m_bits = rand_double(s_bits);
            if ($urandom_range(1))
                send_pair(m_bits, s_bits);
            else
                send_pair(s_bits, m_bits);
        end
    endtask

    // Long receiver stall with the sender still offering beats, so the pipe
    // fills and s_axis_tready must drop.
    initial
    begin
        wait (rst_n);
        repeat (300) @(posedge clk);
        recv_hold = 1'b1;
        repeat (60) @(posedge clk);
        recv_hold = 1'b0;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats with both registers at reset values.
        send_pair(64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0000);  // equal
        send_pair(64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000);  // +0 equals -0
        send_pair(64'h0000_0000_0000_0000, 64'h3ff0_0000_0000_0000);  // zero minuend
        send_pair(64'h8000_0000_0000_0000, 64'hc000_0000_0000_0000);  // -0 minuend
        send_pair(64'h7ff8_0000_0000_0000, 64'h7ff8_0000_0000_0000);  // NaN never equal
        send_pair(64'h3ff0_0000_0000_0000, 64'h7ff0_0000_0000_0000);  // d is -inf
        send_pair(64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000);  // d is +inf
        send_pair(64'h7ff0_0000_0000_0000, 64'h7ff0_0000_0000_0000);  // inf equal
        send_pair(64'h3ff0_0000_0000_0000, 64'hfff8_0000_0000_1234);  // NaN subtrahend
        send_pair(64'h4000_0000_0000_0000, 64'h3ff8_0000_0000_0000);  // small gap
        send_pair(64'h3ff0_0000_0000_0000, 64'hc000_0000_0000_0000);  // d exp above m
        send_pair(64'h3ff0_0000_0000_0001, 64'h3ff0_0000_0000_0000);  // wide gap
        send_pair(64'h4330_0000_0000_0000, 64'h42ff_ffff_ffff_ffff);  // gap of 1
        send_pair(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0002);  // subnormals
        send_pair(64'hffef_ffff_ffff_ffff, 64'h7fef_ffff_ffff_ffff);  // overflow
        send_pair(64'hffff_ffff_ffff_ffff, 64'h0000_0000_0000_0000);  // all ones
        drain();

        // Filter on with a mid threshold of 1e-3.
        write_reg(REG_FILTER_ENABLE, 64'd1);
        write_reg(REG_THRESHOLD, 64'h3f50_624d_d2f1_a9fc);
        send_pair(64'h3ff0_0000_0000_0001, 64'h3ff0_0000_0000_0000);  // filtered
        send_pair(64'h3ff0_0000_0000_0000, 64'h3ff0_0000_0000_0001);  // negative, filtered
        send_pair(64'h4000_0000_0000_0000, 64'h3ff0_0000_0000_0000);  // passes
        send_pair(64'h3ff0_0000_0000_0000, 64'h7ff8_0000_0000_0000);  // NaN d
        drain();
        write_reg(REG_THRESHOLD, 64'h7ff8_0000_0000_0000);            // NaN threshold
        send_pair(64'h3ff0_0000_0000_0001, 64'h3ff0_0000_0000_0000);
        drain();

        // Idling: sender 23 / receiver 66, then swapped, then none.
        send_idle_pct = 23;
        recv_idle_pct = 66;
        write_reg(REG_FILTER_ENABLE, 64'd0);
        write_reg(REG_THRESHOLD, 64'd0);
        random_phase(350);
        drain();

        send_idle_pct = 66;
        recv_idle_pct = 23;
        write_reg(REG_FILTER_ENABLE, 64'd1);
        write_reg(REG_THRESHOLD, 64'h3ff0_0000_0000_0000);            // 1.0
        random_phase(350);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_THRESHOLD, 64'hffff_ffff_ffff_ffff);            // max pattern
        random_phase(100);
        drain();
        write_reg(REG_THRESHOLD, 64'h3e11_2e0b_e826_d695);            // 1e-9
        random_phase(250);
        drain();

        if (sb.errors == 0)
            $display("float_delta_encoder_core_tb OK");
        else
            $display("float_delta_encoder_core_tb NOT OK");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #2ms;
        $display("float_delta_encoder_core_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
